@@ rtl/itr_pkg.sv @@
package itr_pkg;

   // Response buffer depth and its index width
   localparam int RESP_DEPTH = 8;
   localparam int IDX_W      = $clog2(RESP_DEPTH);

   // Bus event codes
   typedef enum logic [2:0] {
      CMD_STOP  = 3'd0,
      CMD_START = 3'd1,
      CMD_ADDR  = 3'd2,
      CMD_TX    = 3'd3,
      CMD_RX    = 3'd4
   } cmd_type;

   // Clock stretch modes
   typedef enum logic [1:0] {
      WAIT_NONE = 2'd0,
      WAIT_8    = 2'd1,
      WAIT_9    = 2'd2
   } wait_type;

   // Register codes carried in the first written byte
   localparam logic [7:0] REG_ID    = 8'h01;
   localparam logic [7:0] REG_CAL_A = 8'hF7;
   localparam logic [7:0] REG_CAL_B = 8'hF8;
   localparam logic [7:0] REG_WR_A  = 8'h50;
   localparam logic [7:0] REG_WR_B  = 8'h51;

   localparam logic [7:0] TX_REM_RESET  = 8'hFF;
   localparam logic [7:0] EXP_LEN_RESET = 8'd2;

   // CSR word index (paddr[2])
   localparam logic CSR_EXP_LEN = 1'b0;

   // One input item
   typedef struct packed {
      logic [2:0] command;
      logic       ack_seen;
      logic       is_read;
      logic       selected;
      logic [7:0] data_byte;
   } item_type;

   // One result item, lowest field in the lowest bits
   typedef struct packed {
      logic [7:0] write_frame_length;
      logic       write_frame_done;
      logic       stop_status;
      logic       not_selected_error;
      logic       rx_done;
      logic       tx_done;
      logic       leave_bus;
      logic       ack_enable;
      logic [1:0] wait_mode;
      logic       release_wait;
      logic [7:0] drive_byte;
      logic       drive_valid;
   } rsp_type;

   // Rebuild request from the core to the response buffer
   typedef struct packed {
      logic       build;
      logic [7:0] sel_reg;
   } buf_wr_type;

   function automatic logic is_read_reg(input logic [7:0] b);
      return (b == REG_ID) || (b == REG_CAL_A) || (b == REG_CAL_B);
   endfunction

   function automatic logic is_write_reg(input logic [7:0] b);
      return (b == REG_WR_A) || (b == REG_WR_B);
   endfunction

   // Number of bytes sent for a read register
   function automatic logic [7:0] resp_len(input logic [7:0] b);
      logic [7:0] len;
      len = 8'd0;
      case (b)
         REG_ID:    len = 8'd3;
         REG_CAL_A: len = 8'd5;
         REG_CAL_B: len = 8'd4;
         default:   len = 8'd0;
      endcase
      return len;
   endfunction

   // Fixed data after the echo byte: {written, value}
   function automatic logic [8:0] resp_byte(input logic [7:0] b, input int idx);
      logic [8:0] r;
      r = 9'd0;
      case (b)
         REG_ID: begin
            case (idx)
               1:       r = {1'b1, 8'h3F};
               2:       r = {1'b1, 8'h0A};
               default: r = 9'd0;
            endcase
         end
         REG_CAL_A: begin
            case (idx)
               1:       r = {1'b1, 8'h04};
               2:       r = {1'b1, 8'h01};
               3:       r = {1'b1, 8'hE2};
               4:       r = {1'b1, 8'hDF};
               default: r = 9'd0;
            endcase
         end
         REG_CAL_B: begin
            case (idx)
               1:       r = {1'b1, 8'h03};
               2:       r = {1'b1, 8'h00};
               3:       r = {1'b1, 8'hFC};
               default: r = 9'd0;
            endcase
         end
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/itr_resp_buf.sv @@
module itr_resp_buf (
   input  logic               clock,
   input  logic               reset,
   input  itr_pkg::buf_wr_type wr,
   input  logic [7:0]         rd_ptr,
   output logic [7:0]         rd_byte
);

   logic [7:0] entry_ff [itr_pkg::RESP_DEPTH];
   logic [8:0] fixed_byte [itr_pkg::RESP_DEPTH];
   logic       in_range;

   // Fixed data per entry for the register being rebuilt: {written, value}
   always_comb begin
      for (int i = 0; i < itr_pkg::RESP_DEPTH; i++) begin
         fixed_byte[i] = itr_pkg::resp_byte(wr.sel_reg, i);
      end
   end

   // Rebuild: echo byte in entry 0, fixed data where the register defines it
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < itr_pkg::RESP_DEPTH; i++) begin
            entry_ff[i] <= 8'd0;
         end
      end else if (wr.build) begin
         for (int i = 0; i < itr_pkg::RESP_DEPTH; i++) begin
            if (i == 0) begin
               entry_ff[i] <= wr.sel_reg;
            end else if (fixed_byte[i][8]) begin
               entry_ff[i] <= fixed_byte[i][7:0];
            end
         end
      end
   end

   // Reads past the buffer give zero
   assign in_range = ({1'b0, rd_ptr} < 9'(itr_pkg::RESP_DEPTH));
   assign rd_byte  = in_range ? entry_ff[rd_ptr[itr_pkg::IDX_W-1:0]] : 8'd0;

endmodule

@@ rtl/itr_core.sv @@
module itr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  itr_pkg::item_type   item,
   input  logic [7:0]          exp_len,
   input  logic [7:0]          rd_byte,
   output logic [7:0]          rd_ptr,
   output itr_pkg::buf_wr_type wr,
   output itr_pkg::rsp_type    rsp
);

   logic       addr_done_ff, addr_done_in;
   logic       rd_flag_ff, rd_flag_in;
   logic       wr_flag_ff, wr_flag_in;
   logic       rx_started_ff, rx_started_in;
   logic [7:0] sel_reg_ff, sel_reg_in;
   logic [7:0] first_rx_ff, first_rx_in;
   logic [7:0] rx_count_ff, rx_count_in;
   logic [7:0] tx_rem_ff, tx_rem_in;
   logic [7:0] tx_ptr_ff, tx_ptr_in;

   logic       addr_eff;
   logic [7:0] fb;

   assign rd_ptr = tx_ptr_ff;

   // Event handling and next state
   always_comb begin
      addr_done_in  = addr_done_ff;
      rd_flag_in    = rd_flag_ff;
      wr_flag_in    = wr_flag_ff;
      rx_started_in = rx_started_ff;
      sel_reg_in    = sel_reg_ff;
      first_rx_in   = first_rx_ff;
      rx_count_in   = rx_count_ff;
      tx_rem_in     = tx_rem_ff;
      tx_ptr_in     = tx_ptr_ff;
      rsp           = '0;
      wr            = '0;
      addr_eff      = addr_done_ff;
      fb            = first_rx_ff;

      case (itr_pkg::cmd_type'(item.command))
         itr_pkg::CMD_STOP: begin
            rsp.stop_status = 1'b1;
            if (wr_flag_ff) begin
               rsp.write_frame_done   = 1'b1;
               rsp.write_frame_length = rx_count_ff;
            end
            rx_count_in  = 8'd0;
            tx_rem_in    = itr_pkg::TX_REM_RESET;
            rd_flag_in   = 1'b0;
            wr_flag_in   = 1'b0;
            addr_done_in = 1'b0;
         end
         itr_pkg::CMD_START, itr_pkg::CMD_ADDR, itr_pkg::CMD_TX, itr_pkg::CMD_RX: begin
            if (item.command == itr_pkg::CMD_START) begin
               addr_eff = 1'b0;
            end
            addr_done_in = addr_eff;
            if (!addr_eff) begin
               // address phase
               if (!item.selected) begin
                  rsp.not_selected_error = 1'b1;
               end else begin
                  addr_done_in = 1'b1;
                  if (item.is_read) begin
                     rsp.wait_mode = itr_pkg::WAIT_9;
                     if (tx_rem_ff != 8'd0) begin
                        rsp.drive_valid = 1'b1;
                        rsp.drive_byte  = rd_byte;
                        tx_ptr_in       = tx_ptr_ff + 8'd1;
                        tx_rem_in       = tx_rem_ff - 8'd1;
                     end else begin
                        rsp.tx_done      = 1'b1;
                        rsp.drive_valid  = 1'b1;
                        rsp.release_wait = 1'b1;
                     end
                  end else begin
                     rx_started_in    = 1'b1;
                     rx_count_in      = 8'd0;
                     rsp.ack_enable   = 1'b1;
                     rsp.wait_mode    = itr_pkg::WAIT_8;
                     rsp.release_wait = 1'b1;
                  end
               end
            end else if (item.command == itr_pkg::CMD_TX ||
                         (item.command == itr_pkg::CMD_ADDR && item.is_read)) begin
               // transmit slot
               if (!item.ack_seen && tx_rem_ff != 8'd0) begin
                  rsp.release_wait = 1'b1;
               end else if (tx_rem_ff != 8'd0) begin
                  rsp.drive_valid = 1'b1;
                  rsp.drive_byte  = rd_byte;
                  tx_ptr_in       = tx_ptr_ff + 8'd1;
                  tx_rem_in       = tx_rem_ff - 8'd1;
               end else begin
                  rsp.tx_done   = 1'b1;
                  rsp.leave_bus = 1'b1;
               end
            end else if (rx_count_ff != 8'hFF) begin
               // received byte
               fb          = (rx_count_ff == 8'd0) ? item.data_byte : first_rx_ff;
               first_rx_in = fb;
               if (itr_pkg::is_read_reg(fb)) begin
                  rd_flag_in = 1'b1;
                  sel_reg_in = fb;
               end else if (itr_pkg::is_write_reg(fb)) begin
                  wr_flag_in = 1'b1;
               end
               if (rd_flag_in) begin
                  wr.build   = 1'b1;
                  wr.sel_reg = sel_reg_in;
                  if (itr_pkg::is_read_reg(sel_reg_in)) begin
                     tx_rem_in = itr_pkg::resp_len(sel_reg_in);
                  end
                  tx_ptr_in = 8'd0;
               end
               rsp.release_wait = 1'b1;
               if (({1'b0, rx_count_ff} + 9'd1) == {1'b0, exp_len} && rx_started_ff) begin
                  rsp.wait_mode = itr_pkg::WAIT_9;
                  rsp.rx_done   = 1'b1;
                  rx_started_in = 1'b0;
               end
               rx_count_in = rx_count_ff + 8'd1;
            end else begin
               // count full: byte dropped
               rsp.release_wait = 1'b1;
            end
         end
         default: begin
            rsp = '0;
         end
      endcase

      if (!fire) begin
         wr = '0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_done_ff  <= 1'b0;
         rd_flag_ff    <= 1'b0;
         wr_flag_ff    <= 1'b0;
         rx_started_ff <= 1'b0;
         sel_reg_ff    <= 8'd0;
         first_rx_ff   <= 8'd0;
         rx_count_ff   <= 8'd0;
         tx_rem_ff     <= itr_pkg::TX_REM_RESET;
         tx_ptr_ff     <= 8'd0;
      end else if (fire) begin
         addr_done_ff  <= addr_done_in;
         rd_flag_ff    <= rd_flag_in;
         wr_flag_ff    <= wr_flag_in;
         rx_started_ff <= rx_started_in;
         sel_reg_ff    <= sel_reg_in;
         first_rx_ff   <= first_rx_in;
         rx_count_ff   <= rx_count_in;
         tx_rem_ff     <= tx_rem_in;
         tx_ptr_ff     <= tx_ptr_in;
      end
   end

endmodule

@@ rtl/i2c_target_register_responder_unit.sv @@
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while rsp_tready is high; while a result waits, the
// input register refills once and then holds its item until the result is taken.
// All event handling is one combinational pass from the input register to the result register.
// Reset (synchronous, active high): bus state cleared, tx remaining 255, response buffer
// zeroed, expected write length 2, no items held.
module i2c_target_register_responder_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], selected[8], is_read[9], ack_seen[10]
   input  logic [2:0]  req_tuser,   // command[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive_valid[0], drive_byte[8:1], release_wait[9],
                                    // wait_mode[11:10], ack_enable[12], leave_bus[13],
                                    // tx_done[14], rx_done[15], not_selected_error[16],
                                    // stop_status[17], write_frame_done[18],
                                    // write_frame_length[26:19]
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                in_valid_ff, in_valid_in;
   itr_pkg::item_type   item_ff;
   logic                out_valid_ff, out_valid_in;
   itr_pkg::rsp_type    rsp_ff;
   itr_pkg::rsp_type    rsp_next;
   logic [7:0]          exp_len_ff;
   logic                advance;
   logic                req_fire;
   logic                csr_wr;
   itr_pkg::buf_wr_type buf_wr;
   logic [7:0]          rd_ptr;
   logic [7:0]          rd_byte;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == itr_pkg::CSR_EXP_LEN) ? {24'd0, exp_len_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= itr_pkg::EXP_LEN_RESET;
      end else if (csr_wr && csr_paddr[2] == itr_pkg::CSR_EXP_LEN) begin
         exp_len_ff <= csr_pwdata[7:0];
      end
   end

   // Handshake: process when the result register is free or being drained
   assign advance     = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready  = ~in_valid_ff | advance;
   assign req_fire    = req_tvalid & req_tready;
   assign in_valid_in = req_fire | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.command   <= req_tuser;
         item_ff.data_byte <= req_tdata[7:0];
         item_ff.selected  <= req_tdata[8];
         item_ff.is_read   <= req_tdata[9];
         item_ff.ack_seen  <= req_tdata[10];
      end
   end

   itr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (item_ff),
      .exp_len (exp_len_ff),
      .rd_byte (rd_byte),
      .rd_ptr  (rd_ptr),
      .wr      (buf_wr),
      .rsp     (rsp_next)
   );

   itr_resp_buf u_resp_buf (
      .clock   (clock),
      .reset   (reset),
      .wr      (buf_wr),
      .rd_ptr  (rd_ptr),
      .rd_byte (rd_byte)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

   // An item waiting with a free result register moves on next cycle
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("item stuck in input register");

   // A stop result never loads a byte or ends receive
   a_stop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.stop_status) |-> (!rsp_ff.drive_valid && !rsp_ff.rx_done))
      else $error("stop result carries transfer fields");

   // An address mismatch gives nothing else
   a_nosel_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.not_selected_error) |->
      (!rsp_ff.drive_valid && !rsp_ff.release_wait && !rsp_ff.ack_enable))
      else $error("address mismatch result carries other fields");

   // Wait mode code 3 is never produced
   a_wait_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff.wait_mode != 2'd3))
      else $error("bad wait mode");

endmodule

@@ verif/tb_i2c_target_register_responder_unit.sv @@
`timescale 1ns / 1ps

module tb_i2c_target_register_responder_unit;

   localparam int         CYCLE_LIMIT   = 300000;
   localparam int         TAIL_CYCLES   = 20;
   localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
   localparam logic [2:0] CMD_BAD_LAST  = 3'd7;

   // What the driver pops next: a bus event, a register write, or a pause
   typedef enum logic [1:0] {
      STEP_EVENT,
      STEP_CSR,
      STEP_PAUSE
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [2:0]    cmd;
      logic [7:0]    data;
      logic          sel;
      logic          rd;
      logic          ack;
      logic [7:0]    value;
   } bus_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // data_byte[7:0], selected[8], is_read[9], ack_seen[10]
   logic [2:0]  req_tuser = '0;   // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // drive_valid[0], drive_byte[8:1], release_wait[9],
                                  // wait_mode[11:10], ack_enable[12], leave_bus[13],
                                  // tx_done[14], rx_done[15], not_selected_error[16],
                                  // stop_status[17], write_frame_done[18],
                                  // write_frame_length[26:19]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   i2c_target_register_responder_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Predicted bus state, reset values
   logic [7:0] write_len  = itr_pkg::EXP_LEN_RESET;
   logic       addr_done  = 1'b0;
   logic       rd_flag    = 1'b0;
   logic       wr_flag    = 1'b0;
   logic       rx_active  = 1'b0;
   logic [7:0] sel_reg    = '0;
   logic [7:0] first_byte = '0;
   logic [7:0] rx_cnt     = '0;
   logic [7:0] tx_left    = itr_pkg::TX_REM_RESET;
   logic [7:0] tx_ptr     = '0;
   logic [7:0] resp_buf [itr_pkg::RESP_DEPTH];

   bus_step_type      pending_steps [$];
   itr_pkg::rsp_type  expected_rsp [$];

   int  cycle_cnt      = 0;
   int  mismatch_cnt   = 0;
   int  queued_events  = 0;
   int  events_taken   = 0;
   int  results_seen   = 0;
   int  csr_writes     = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  csr_stage      = 0;
   logic req_accepted  = 1'b0;

   initial begin
      for (int i = 0; i < itr_pkg::RESP_DEPTH; i++) resp_buf[i] = '0;
   end

   // Echo byte plus the register's fixed data; older bytes past it stay
   function automatic void rebuild_response();
      resp_buf[0] = sel_reg;
      case (sel_reg)
         itr_pkg::REG_ID: begin
            tx_left = 8'd3;
            resp_buf[1] = 8'h3F; resp_buf[2] = 8'h0A;
         end
         itr_pkg::REG_CAL_A: begin
            tx_left = 8'd5;
            resp_buf[1] = 8'h04; resp_buf[2] = 8'h01;
            resp_buf[3] = 8'hE2; resp_buf[4] = 8'hDF;
         end
         itr_pkg::REG_CAL_B: begin
            tx_left = 8'd4;
            resp_buf[1] = 8'h03; resp_buf[2] = 8'h00; resp_buf[3] = 8'hFC;
         end
         default: ;
      endcase
      tx_ptr = '0;
   endfunction

   // Byte at the transmit pointer, zero past the buffer
   function automatic logic [7:0] next_tx_byte();
      logic [7:0] v;
      v = (tx_ptr < itr_pkg::RESP_DEPTH) ? resp_buf[tx_ptr[itr_pkg::IDX_W-1:0]] : 8'h00;
      tx_ptr  = tx_ptr + 8'd1;
      tx_left = tx_left - 8'd1;
      return v;
   endfunction

   function automatic itr_pkg::rsp_type bus_event_response(input logic [2:0] cmd,
                                                           input logic [7:0] data,
                                                           input logic sel, input logic rd,
                                                           input logic ack);
      itr_pkg::rsp_type r;
      r = '0;
      if (cmd > itr_pkg::CMD_RX) return r;

      if (cmd == itr_pkg::CMD_STOP) begin
         r.stop_status = 1'b1;
         if (wr_flag) begin
            r.write_frame_done   = 1'b1;
            r.write_frame_length = rx_cnt;
         end
         rx_cnt    = '0;
         tx_left   = itr_pkg::TX_REM_RESET;
         rd_flag   = 1'b0;
         wr_flag   = 1'b0;
         addr_done = 1'b0;
         return r;
      end

      if (cmd == itr_pkg::CMD_START) addr_done = 1'b0;

      // address phase
      if (!addr_done) begin
         if (!sel) begin
            r.not_selected_error = 1'b1;
            return r;
         end
         addr_done = 1'b1;
         if (rd) begin
            r.wait_mode = itr_pkg::WAIT_9;
            if (tx_left != 0) begin
               r.drive_valid = 1'b1;
               r.drive_byte  = next_tx_byte();
            end else begin
               r.tx_done      = 1'b1;
               r.drive_valid  = 1'b1;
               r.release_wait = 1'b1;
            end
         end else begin
            rx_active      = 1'b1;
            rx_cnt         = '0;
            r.ack_enable   = 1'b1;
            r.wait_mode    = itr_pkg::WAIT_8;
            r.release_wait = 1'b1;
         end
         return r;
      end

      // transmit slot
      if (cmd == itr_pkg::CMD_TX || (cmd == itr_pkg::CMD_ADDR && rd)) begin
         if (!ack && tx_left != 0) begin
            r.release_wait = 1'b1;
         end else if (tx_left != 0) begin
            r.drive_valid = 1'b1;
            r.drive_byte  = next_tx_byte();
         end else begin
            r.tx_done   = 1'b1;
            r.leave_bus = 1'b1;
         end
         return r;
      end

      // received byte; dropped once the count is full
      r.release_wait = 1'b1;
      if (rx_cnt != 8'hFF) begin
         if (rx_cnt == 0) first_byte = data;
         if (first_byte == itr_pkg::REG_ID || first_byte == itr_pkg::REG_CAL_A ||
             first_byte == itr_pkg::REG_CAL_B) begin
            rd_flag = 1'b1;
            sel_reg = first_byte;
         end else if (first_byte == itr_pkg::REG_WR_A || first_byte == itr_pkg::REG_WR_B) begin
            wr_flag = 1'b1;
         end
         if (rd_flag) rebuild_response();
         if (({1'b0, rx_cnt} + 9'd1) == {1'b0, write_len} && rx_active) begin
            r.wait_mode = itr_pkg::WAIT_9;
            r.rx_done   = 1'b1;
            rx_active   = 1'b0;
         end
         rx_cnt = rx_cnt + 8'd1;
      end
      return r;
   endfunction

   function automatic void field_mismatch(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
      mismatch_cnt++;
      $error("%s: expected %0h, got %0h", name, want, got);
   endfunction

   function automatic void compare_result(input itr_pkg::rsp_type got,
                                          input itr_pkg::rsp_type want);
      if (got.drive_valid !== want.drive_valid)
         field_mismatch("drive_valid", 8'(want.drive_valid), 8'(got.drive_valid));
      if (got.drive_byte !== want.drive_byte)
         field_mismatch("drive_byte", want.drive_byte, got.drive_byte);
      if (got.release_wait !== want.release_wait)
         field_mismatch("release_wait", 8'(want.release_wait), 8'(got.release_wait));
      if (got.wait_mode !== want.wait_mode)
         field_mismatch("wait_mode", 8'(want.wait_mode), 8'(got.wait_mode));
      if (got.ack_enable !== want.ack_enable)
         field_mismatch("ack_enable", 8'(want.ack_enable), 8'(got.ack_enable));
      if (got.leave_bus !== want.leave_bus)
         field_mismatch("leave_bus", 8'(want.leave_bus), 8'(got.leave_bus));
      if (got.tx_done !== want.tx_done)
         field_mismatch("tx_done", 8'(want.tx_done), 8'(got.tx_done));
      if (got.rx_done !== want.rx_done)
         field_mismatch("rx_done", 8'(want.rx_done), 8'(got.rx_done));
      if (got.not_selected_error !== want.not_selected_error)
         field_mismatch("not_selected_error", 8'(want.not_selected_error),
                        8'(got.not_selected_error));
      if (got.stop_status !== want.stop_status)
         field_mismatch("stop_status", 8'(want.stop_status), 8'(got.stop_status));
      if (got.write_frame_done !== want.write_frame_done)
         field_mismatch("write_frame_done", 8'(want.write_frame_done),
                        8'(got.write_frame_done));
      if (got.write_frame_length !== want.write_frame_length)
         field_mismatch("write_frame_length", want.write_frame_length, got.write_frame_length);
   endfunction

   // Idle length: mostly none, some short, a few long; quiet stretches without any
   function automatic int pick_gap();
      int r;
      if ((cycle_cnt / 256) % 4 == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Cycle count and timeout
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Monitor: check results, predict each accepted item
   always @(posedge clock) begin : watch_bus
      itr_pkg::rsp_type got;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = itr_pkg::rsp_type'(rsp_tdata[$bits(itr_pkg::rsp_type)-1:0]);
            results_seen++;
            if (expected_rsp.size() == 0) begin
               mismatch_cnt++;
               $error("result with nothing expected: %h", rsp_tdata);
            end else begin
               compare_result(got, expected_rsp.pop_front());
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(bus_event_response(req_tuser, req_tdata[7:0], req_tdata[8],
                                                      req_tdata[9], req_tdata[10]));
            events_taken++;
         end
         req_accepted <= req_tvalid && req_tready;
      end
   end

   // Driver: bus events, register writes and pauses from the pending queue
   always @(negedge clock) begin : drive_req
      logic         valid_n;
      bus_step_type nxt;
      valid_n = req_tvalid && !req_accepted;
      if (!reset && !valid_n) begin
         if (csr_stage == 1) begin
            csr_penable <= 1'b1;
            csr_stage = 2;
         end else if (csr_stage == 2) begin
            // register took the write at the last rising edge
            csr_psel    <= 1'b0;
            csr_penable <= 1'b0;
            csr_pwrite  <= 1'b0;
            write_len = csr_pwdata[7:0];
            csr_writes++;
            csr_stage = 0;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_steps.size() > 0) begin
            nxt = pending_steps[0];
            if (nxt.kind == STEP_EVENT) begin
               void'(pending_steps.pop_front());
               req_tdata <= {5'b0, nxt.ack, nxt.rd, nxt.sel, nxt.data};
               req_tuser <= nxt.cmd;
               valid_n = 1'b1;
               gap_left = pick_gap();
            end else if (expected_rsp.size() == 0) begin
               // register writes and pauses wait for the block to go idle
               void'(pending_steps.pop_front());
               if (nxt.kind == STEP_CSR) begin
                  csr_psel   <= 1'b1;
                  csr_pwrite <= 1'b1;
                  csr_paddr  <= {itr_pkg::CSR_EXP_LEN, 2'b00};
                  csr_pwdata <= {24'h0, nxt.value};
                  csr_stage = 1;
               end
            end
         end
      end
      req_tvalid <= valid_n;
   end

   // Result side stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   function automatic logic [7:0] rb();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [7:0] pick_register();
      case ($urandom_range(0, 5))
         0: return itr_pkg::REG_ID;
         1: return itr_pkg::REG_CAL_A;
         2: return itr_pkg::REG_CAL_B;
         3: return itr_pkg::REG_WR_A;
         4: return itr_pkg::REG_WR_B;
         default: return rb();
      endcase
   endfunction

   function automatic logic [2:0] pick_command();
      if ($urandom_range(0, 15) == 0)
         return 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
      return 3'($urandom_range(itr_pkg::CMD_STOP, itr_pkg::CMD_RX));
   endfunction

   task automatic add_event(input logic [2:0] cmd, input logic [7:0] data, input logic sel,
                            input logic rd, input logic ack);
      bus_step_type s;
      s = '{kind: STEP_EVENT, cmd: cmd, data: data, sel: sel, rd: rd, ack: ack, value: '0};
      pending_steps.push_back(s);
      queued_events++;
   endtask

   task automatic add_step(input step_kind_type kind, input logic [7:0] value);
      bus_step_type s;
      s = '{kind: kind, cmd: '0, data: '0, sel: 1'b0, rd: 1'b0, ack: 1'b0, value: value};
      pending_steps.push_back(s);
   endtask

   // Write frame: register byte, then n-1 data bytes
   task automatic write_frame(input logic [7:0] reg_byte, input int n);
      add_event(itr_pkg::CMD_START, rb(), 1'b1, 1'b0, coin());
      add_event(itr_pkg::CMD_RX, reg_byte, coin(), coin(), coin());
      repeat (n - 1) add_event(itr_pkg::CMD_RX, rb(), coin(), coin(), coin());
      add_event(itr_pkg::CMD_STOP, rb(), coin(), coin(), coin());
   endtask

   // Register select, restart for read, n transmit slots
   task automatic read_frame(input logic [7:0] reg_byte, input int n);
      add_event(itr_pkg::CMD_START, rb(), 1'b1, 1'b0, coin());
      add_event(itr_pkg::CMD_RX, reg_byte, coin(), coin(), coin());
      add_event(itr_pkg::CMD_START, rb(), 1'b1, 1'b1, coin());
      repeat (n) add_event(itr_pkg::CMD_TX, rb(), coin(), coin(), $urandom_range(0, 9) != 0);
      add_event(itr_pkg::CMD_STOP, rb(), coin(), coin(), coin());
   endtask

   task automatic add_random_sequence();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: write_frame(pick_register(), $urandom_range(1, 6));
         3, 4, 5: read_frame(pick_register(), $urandom_range(1, 7));
         6: begin
            // noise
            n = $urandom_range(1, 4);
            repeat (n) add_event(pick_command(), rb(), coin(), coin(), coin());
         end
         7: begin
            // frame cut by a restart, no stop
            add_event(itr_pkg::CMD_START, rb(), 1'b1, 1'b0, coin());
            add_event(itr_pkg::CMD_RX, pick_register(), coin(), coin(), coin());
            add_event(itr_pkg::CMD_START, rb(), coin(), coin(), coin());
         end
         8: begin
            // address phase without start; direction bit picks send or receive
            add_event(itr_pkg::CMD_STOP, rb(), coin(), coin(), coin());
            add_event(itr_pkg::CMD_ADDR, pick_register(), $urandom_range(0, 7) != 0,
                      coin(), coin());
            n = $urandom_range(1, 5);
            repeat (n) add_event(itr_pkg::CMD_ADDR, pick_register(), coin(), coin(), coin());
         end
         default: begin
            // start that misses our address
            add_event(itr_pkg::CMD_START, rb(), 1'b0, coin(), coin());
            add_event(itr_pkg::CMD_RX, rb(), coin(), coin(), coin());
            add_event(itr_pkg::CMD_STOP, rb(), coin(), coin(), coin());
         end
      endcase
   endtask

   initial begin
      // Directed: unmatched address, unknown commands, reads with no register
      add_event(itr_pkg::CMD_ADDR, 8'hFF, 1'b0, 1'b1, 1'b1);
      for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++)
         add_event(c[2:0], 8'hFF, 1'b1, 1'b1, 1'b1);
      add_event(itr_pkg::CMD_START, 8'h00, 1'b1, 1'b1, 1'b0);
      add_event(itr_pkg::CMD_TX, 8'h00, 1'b1, 1'b1, 1'b0);   // nack with data left
      add_event(itr_pkg::CMD_TX, 8'h00, 1'b1, 1'b1, 1'b1);
      add_event(itr_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
      // select a read register, receive end at length 2, read it all and past the end
      add_event(itr_pkg::CMD_START, 8'h00, 1'b1, 1'b0, 1'b0);
      add_event(itr_pkg::CMD_RX, itr_pkg::REG_CAL_A, 1'b0, 1'b0, 1'b0);
      add_event(itr_pkg::CMD_RX, 8'h00, 1'b0, 1'b0, 1'b0);
      add_event(itr_pkg::CMD_START, 8'h00, 1'b1, 1'b1, 1'b1);
      repeat (5) add_event(itr_pkg::CMD_TX, 8'h00, 1'b0, 1'b0, 1'b1);
      add_event(itr_pkg::CMD_START, 8'h00, 1'b1, 1'b1, 1'b1);  // nothing left: dummy byte
      add_event(itr_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
      // write register frame reported at stop
      add_event(itr_pkg::CMD_START, 8'h00, 1'b1, 1'b0, 1'b0);
      add_event(itr_pkg::CMD_RX, itr_pkg::REG_WR_B, 1'b0, 1'b0, 1'b0);
      add_event(itr_pkg::CMD_RX, 8'hFF, 1'b1, 1'b1, 1'b1);
      add_event(itr_pkg::CMD_STOP, 8'hFF, 1'b1, 1'b1, 1'b1);

      // Shortest expected write length
      add_step(STEP_CSR, 8'd1);
      while (queued_events < 110) add_random_sequence();
      add_step(STEP_PAUSE, '0);
      while (queued_events < 150) add_random_sequence();

      // Longest length, with a frame that fills the receive count
      add_step(STEP_CSR, 8'd255);
      write_frame(itr_pkg::REG_WR_A, 260);
      while (queued_events < 430) add_random_sequence();

      // Mid length; a long read past the buffer that wraps the pointer
      add_step(STEP_CSR, 8'($urandom_range(3, 254)));
      read_frame(itr_pkg::REG_ID, 3);
      add_event(itr_pkg::CMD_START, rb(), 1'b1, 1'b1, coin());
      repeat (258) add_event(itr_pkg::CMD_TX, rb(), coin(), coin(), 1'b1);
      add_event(itr_pkg::CMD_STOP, rb(), coin(), coin(), coin());
      while (queued_events < 700) add_random_sequence();

      // Back to the reset length
      add_step(STEP_CSR, itr_pkg::EXP_LEN_RESET);
      while (queued_events < 800) add_random_sequence();

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_steps.size() != 0 || req_tvalid || csr_stage != 0 ||
             expected_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d bus events, checked %0d results, %0d write length settings;",
               events_taken, results_seen, csr_writes);
      $display("included full receive count, reads past the buffer and unknown commands.");
      if (mismatch_cnt == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/itr_pkg.sv
rtl/itr_resp_buf.sv
rtl/itr_core.sv
rtl/i2c_target_register_responder_unit.sv
verif/tb_i2c_target_register_responder_unit.sv
